[src/btk_pkg.sv]
// Package for the bounded top-k nearest answer set.
// Holds opcodes, the stored entry type and the controller/datapath command
// and status structs. Depends on nothing.
`default_nettype none
package btk_pkg;

    localparam int BTK_MAX_K   = 64;
    localparam int DIST_W      = 32;
    localparam int CAP_W       = 7;
    localparam int CNT_OUT_W   = 7;
    localparam logic [CAP_W-1:0] CAP_RESET = 7'd10;

    localparam logic [1:0] OP_PUSH  = 2'd0;
    localparam logic [1:0] OP_CHECK = 2'd1;
    localparam logic [1:0] OP_POP   = 2'd2;
    localparam logic [1:0] OP_NOP   = 2'd3;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic [31:0]       node;
        logic [31:0]       offset;
        logic [31:0]       query;
    } entry_t;

    typedef struct packed {
        logic load_in;     // latch the accepted item
        logic clr_scan;    // restart the index at zero
        logic rd_cur;      // read the entry at the index
        logic cmp;         // compare read data with the running largest
        logic set_i_best;  // move the index to the largest entry
        logic set_pop;     // keep the largest entry as the popped answer
        logic set_err;     // flag a pop on an empty set
        logic rd_next;     // read the entry after the index
        logic wr_shift;    // write read data one place down
        logic dec;         // drop one entry from the count
        logic app;         // append the held item
        logic bsf_upd;     // refresh best-so-far
        logic out_load;    // load the result register
    } cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       full;
        logic       d_lt_bsf;
        logic       cnt_zero;
        logic       scan_last;
        logic       rm_more;
        logic       out_busy;
    } sts_t;

endpackage
`default_nettype wire

[src/btk_ifs.sv]
// Channel interfaces for the top-k answer set: candidate, result, config.
// Depend on nothing.
`default_nettype none
interface btk_cand_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [31:0] distance;
    logic [31:0] node_id;
    logic [31:0] series_offset;
    logic [31:0] query_number;
    modport source (output valid, opcode, distance, node_id, series_offset,
                    query_number, input ready);
    modport sink (input valid, opcode, distance, node_id, series_offset,
                  query_number, output ready);
endinterface

interface btk_result_if;
    logic        valid;
    logic        ready;
    logic [31:0] out_distance;
    logic [31:0] out_node_id;
    logic [31:0] out_offset;
    logic [31:0] out_query;
    logic [31:0] best_so_far;
    logic [6:0]  count;
    logic        status;
    modport source (output valid, out_distance, out_node_id, out_offset, out_query,
                    best_so_far, count, status, input ready);
    modport sink (input valid, out_distance, out_node_id, out_offset, out_query,
                  best_so_far, count, status, output ready);
endinterface

interface btk_cfg_if;
    logic       valid;
    logic       ready;
    logic [6:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

[src/btk_ctrl.sv]
// Sequencer for the top-k answer set: scans, shifts and appends.
// Depends on btk_pkg.
`default_nettype none
module btk_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire btk_pkg::sts_t sts,
    output btk_pkg::cmd_t      cmd
);
    import btk_pkg::*;

    typedef enum logic [11:0] {
        S_IDLE   = 12'b000000000001,
        S_DECIDE = 12'b000000000010,
        S_SRD    = 12'b000000000100,
        S_SCMP   = 12'b000000001000,
        S_RSET   = 12'b000000010000,
        S_RTST   = 12'b000000100000,
        S_RWR    = 12'b000001000000,
        S_APP    = 12'b000010000000,
        S_FSTART = 12'b000100000000,
        S_FRD    = 12'b001000000000,
        S_FCMP   = 12'b010000000000,
        S_DONE   = 12'b100000000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        in_ready   = 1'b0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                priority if (sts.op == OP_POP)
                begin
                    if (sts.cnt_zero)
                    begin
                        cmd.set_err = 1'b1;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        cmd.clr_scan = 1'b1;
                        state_next   = S_SRD;
                    end
                end
                else if (sts.op == OP_NOP)
                begin
                    state_next = S_DONE;
                end
                else if (sts.op == OP_CHECK && !sts.d_lt_bsf)
                begin
                    state_next = S_DONE;
                end
                else if (sts.full)
                begin
                    // A full set keeps the item only if it beats the largest.
                    if (sts.d_lt_bsf)
                    begin
                        cmd.clr_scan = 1'b1;
                        state_next   = S_SRD;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    state_next = S_APP;
                end
            end
            S_SRD:
            begin
                cmd.rd_cur = 1'b1;
                state_next = S_SCMP;
            end
            S_SCMP:
            begin
                cmd.cmp    = 1'b1;
                state_next = sts.scan_last ? S_RSET : S_SRD;
            end
            S_RSET:
            begin
                cmd.set_i_best = 1'b1;
                cmd.set_pop    = (sts.op == OP_POP);
                state_next     = S_RTST;
            end
            S_RTST:
            begin
                if (sts.rm_more)
                begin
                    cmd.rd_next = 1'b1;
                    state_next  = S_RWR;
                end
                else
                begin
                    cmd.dec    = 1'b1;
                    state_next = (sts.op == OP_POP) ? S_FSTART : S_APP;
                end
            end
            S_RWR:
            begin
                cmd.wr_shift = 1'b1;
                state_next   = S_RTST;
            end
            S_APP:
            begin
                cmd.app    = 1'b1;
                state_next = S_FSTART;
            end
            S_FSTART:
            begin
                if (sts.cnt_zero)
                begin
                    cmd.bsf_upd = 1'b1;
                    state_next  = S_DONE;
                end
                else
                begin
                    cmd.clr_scan = 1'b1;
                    state_next   = S_FRD;
                end
            end
            S_FRD:
            begin
                cmd.rd_cur = 1'b1;
                state_next = S_FCMP;
            end
            S_FCMP:
            begin
                cmd.cmp = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_FRD;
                end
            end
            S_DONE:
            begin
                if (!sts.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        // Best-so-far follows the final compare of a refresh scan.
        if (state_reg == S_FCMP && sts.scan_last)
        begin
            cmd.bsf_upd = 1'b0;
        end
    end

endmodule
`default_nettype wire

[src/btk_datapath.sv]
// Datapath for the top-k answer set: entry memory, count, best-so-far,
// scan registers and the result register. Depends on btk_pkg.
`default_nettype none
module btk_datapath #(
    parameter int MAX_K = btk_pkg::BTK_MAX_K
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire btk_pkg::cmd_t             cmd,
    output btk_pkg::sts_t                  sts,
    input  wire logic                      cfg_we,
    input  wire logic [btk_pkg::CAP_W-1:0] cfg_data,
    input  wire logic [1:0]                in_opcode,
    input  wire btk_pkg::entry_t           in_entry,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output btk_pkg::entry_t                out_entry,
    output logic [31:0]                    out_bsf,
    output logic [btk_pkg::CNT_OUT_W-1:0]  out_count,
    output logic                           out_status
);
    import btk_pkg::*;

    localparam int AW = (MAX_K > 1) ? $clog2(MAX_K) : 1;
    localparam int CW = $clog2(MAX_K + 1);
    localparam int XW = (CW > CAP_W) ? CW : CAP_W;
    localparam logic [XW-1:0] MAXK_X = XW'(MAX_K);

    entry_t mem [MAX_K];
    entry_t rdata_reg, held_reg, best_reg, pop_reg;
    logic [1:0]        op_reg;
    logic [CW-1:0]     count_reg, idx_reg, best_idx_reg;
    logic [31:0]       bsf_reg;
    logic [CAP_W-1:0]  cap_reg;
    logic              pop_ok_reg, err_reg;

    logic [CW-1:0] idx_inc;
    logic [XW-1:0] cap_x, cap_eff;

    // The refresh scan ends with a compare; best-so-far takes the winner of
    // that compare in the same edge.
    logic        refresh_reg;
    logic        bsf_from_scan;
    logic [31:0] bsf_scan_val;

    assign idx_inc = idx_reg + CW'(1);

    always_comb
    begin
        cap_x = XW'(cap_reg);
        priority if (cap_x == '0)
        begin
            cap_eff = XW'(1);
        end
        else if (cap_x > MAXK_X)
        begin
            cap_eff = MAXK_X;
        end
        else
        begin
            cap_eff = cap_x;
        end
    end

    assign sts.op        = op_reg;
    assign sts.full      = XW'(count_reg) >= cap_eff;
    assign sts.d_lt_bsf  = held_reg.distance < bsf_reg;
    assign sts.cnt_zero  = (count_reg == '0);
    assign sts.scan_last = (idx_inc == count_reg);
    assign sts.rm_more   = (idx_inc < count_reg);
    assign sts.out_busy  = out_valid && !out_ready;

    // Entry memory: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (cmd.app)
        begin
            mem[count_reg[AW-1:0]] <= held_reg;
        end
        else if (cmd.wr_shift)
        begin
            mem[idx_reg[AW-1:0]] <= rdata_reg;
        end
        if (cmd.rd_cur)
        begin
            rdata_reg <= mem[idx_reg[AW-1:0]];
        end
        else if (cmd.rd_next)
        begin
            rdata_reg <= mem[idx_inc[AW-1:0]];
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            held_reg <= in_entry;
            op_reg   <= in_opcode;
        end
        if (cmd.cmp && (idx_reg == '0 || rdata_reg.distance > best_reg.distance))
        begin
            best_reg     <= rdata_reg;
            best_idx_reg <= idx_reg;
        end
        if (cmd.set_pop)
        begin
            pop_reg <= best_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            idx_reg    <= '0;
            bsf_reg    <= '1;
            cap_reg    <= CAP_RESET;
            pop_ok_reg <= 1'b0;
            err_reg    <= 1'b0;
            out_valid  <= 1'b0;
            out_entry  <= '0;
            out_bsf    <= '1;
            out_count  <= '0;
            out_status <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                cap_reg <= cfg_data;
            end
            if (cmd.load_in)
            begin
                pop_ok_reg <= 1'b0;
                err_reg    <= 1'b0;
            end
            if (cmd.set_pop)
            begin
                pop_ok_reg <= 1'b1;
            end
            if (cmd.set_err)
            begin
                err_reg <= 1'b1;
            end
            priority if (cmd.clr_scan)
            begin
                idx_reg <= '0;
            end
            else if (cmd.set_i_best)
            begin
                idx_reg <= best_idx_reg;
            end
            else if (cmd.cmp || cmd.wr_shift)
            begin
                idx_reg <= idx_inc;
            end
            if (cmd.app)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (cmd.dec)
            begin
                count_reg <= count_reg - CW'(1);
            end
            if (cmd.bsf_upd)
            begin
                bsf_reg <= '1;
            end
            else if (bsf_from_scan)
            begin
                bsf_reg <= bsf_scan_val;
            end
            if (cmd.out_load)
            begin
                out_valid  <= 1'b1;
                out_entry  <= pop_ok_reg ? pop_reg : '0;
                out_bsf    <= bsf_reg;
                out_count  <= CNT_OUT_W'(count_reg);
                out_status <= err_reg;
            end
            else if (out_ready)
            begin
                out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            refresh_reg <= 1'b0;
        end
        else if (cmd.app || cmd.dec)
        begin
            refresh_reg <= 1'b1;
        end
        else if (cmd.out_load)
        begin
            refresh_reg <= 1'b0;
        end
    end

    assign bsf_from_scan = refresh_reg && cmd.cmp && sts.scan_last;
    assign bsf_scan_val  = (idx_reg == '0 || rdata_reg.distance > best_reg.distance) ?
                           rdata_reg.distance : best_reg.distance;

endmodule
`default_nettype wire

[src/bounded_topk_nearest_set_top.sv]
// Top level of the bounded top-k nearest answer set.
// Depends on btk_pkg, btk_ifs, btk_ctrl and btk_datapath.
//
// The block keeps the k answers of smallest distance. Items arrive on the
// cand channel (valid/ready); opcode 0 pushes, 1 pushes only when the
// distance is below best-so-far, 2 pops the largest entry, 3 does nothing.
// Each item yields exactly one item on the result channel, holding the
// popped entry (zero unless a pop succeeded), best-so-far, the count and
// an error flag for a pop on an empty set.
// The capacity register is written on the cfg channel, which is always
// ready; write it only while the block is idle.
// Items are handled one at a time by a sequencer over a single-port entry
// memory; the result becomes valid in the same cycle as the block is ready
// for the next item. A push into a set that is not full appends the item
// and scans the entries for the new best-so-far. An evicting push or a
// pop scans the entries, shifts the later ones down and scans again for
// the new best-so-far. A dropped push, a no-op or a pop on an empty set
// goes straight to the result.
// The result waits in an output register; when the receiver stalls the
// block finishes the item and then holds until the result is taken.
// Reset empties the set, sets best-so-far to all ones and capacity to ten.
`default_nettype none
module bounded_topk_nearest_set_top #(
    parameter int MAX_K = btk_pkg::BTK_MAX_K
) (
    input wire logic     clk,
    input wire logic     rst_n,
    btk_cand_if.sink     cand,
    btk_result_if.source result,
    btk_cfg_if.sink      cfg
);
    import btk_pkg::*;

    cmd_t   cmd;
    sts_t   sts;
    entry_t in_entry;
    entry_t out_entry;

    assign cfg.ready = 1'b1;

    assign in_entry.distance = cand.distance;
    assign in_entry.node     = cand.node_id;
    assign in_entry.offset   = cand.series_offset;
    assign in_entry.query    = cand.query_number;

    assign result.out_distance = out_entry.distance;
    assign result.out_node_id  = out_entry.node;
    assign result.out_offset   = out_entry.offset;
    assign result.out_query    = out_entry.query;

    btk_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cand.valid),
        .in_ready (cand.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    btk_datapath #(
        .MAX_K (MAX_K)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .cfg_we     (cfg.valid),
        .cfg_data   (cfg.data),
        .in_opcode  (cand.opcode),
        .in_entry   (in_entry),
        .out_valid  (result.valid),
        .out_ready  (result.ready),
        .out_entry  (out_entry),
        .out_bsf    (result.best_so_far),
        .out_count  (result.count),
        .out_status (result.status)
    );

endmodule
`default_nettype wire
